[rtl/core/bfr_pkg.sv]
// Shared constants and the 5x7 font table for the bitmap font text rasterizer.
// No dependencies; imported by bitmap_font_text_rasterizer.
`default_nettype none

package bfr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int RECT_W         = 16;
    localparam int COLOR_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int SCALE_W        = 5;
    localparam int START_W        = 16;
    localparam int GLYPH_ROWS     = 7;
    localparam int GLYPH_COLS     = 5;
    localparam int GLYPH_BITS     = GLYPH_ROWS * GLYPH_COLS;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR   = 2'd3;

    localparam logic [SCALE_W-1:0]  SCALE_RST = 5'd2;
    localparam logic [START_W-1:0]  START_RST = 16'd16;
    localparam logic [COLOR_W-1:0]  COLOR_RST = 32'hFFFF_FFFF;

    typedef logic [GLYPH_BITS-1:0] t_glyph;

    // Glyph rows packed top row in the high bits; bit 4 of a row is its leftmost column.
    // Lower-case letters fold to upper case, anything not in the font is blank.
    function automatic t_glyph glyph_bits(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        t_glyph g;
        c = code;
        if (code >= 8'h61 && code <= 8'h7A) begin
            c = code - 8'd32;
        end
        case (c)
            8'h2D: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}; // -
            8'h2E: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06}; // .
            8'h3A: g = {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00}; // :
            8'h30: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
            8'h31: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
            8'h32: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
            8'h33: g = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
            8'h34: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
            8'h35: g = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
            8'h36: g = {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E};
            8'h37: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
            8'h38: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
            8'h39: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E};
            8'h41: g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            8'h42: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
            8'h43: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
            8'h44: g = {5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C};
            8'h45: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
            8'h46: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
            8'h47: g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F};
            8'h48: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            8'h49: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
            8'h4A: g = {5'h01,5'h01,5'h01,5'h01,5'h11,5'h11,5'h0E};
            8'h4B: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
            8'h4C: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
            8'h4D: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
            8'h4E: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
            8'h4F: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            8'h50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
            8'h51: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
            8'h52: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
            8'h53: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
            8'h54: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
            8'h55: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            8'h56: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
            8'h57: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A};
            8'h58: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
            8'h59: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
            8'h5A: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
            default: g = '0; // space and unknown bytes
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bitmap_font_text_rasterizer.sv]
// Bitmap font text rasterizer: one character in, one filled square out per lit glyph pixel.
// Depends on bfr_pkg (font table, register indexes, widths).
`default_nettype none

// Each request on the slave side carries one character byte (tdata) and a new-string flag
// (tuser). A newline (byte 10) only moves the cursor: x back to start_x, y down by
// 9 x pixel_scale; it produces nothing. Any other byte is upper-cased and looked up in the
// 5x7 font; unknown bytes draw blank but still advance the cursor. A glyph is scanned by one
// sequencer, one candidate pixel per cycle unless a lit one waits on the master side, row
// by row and left to right, through shared x and y adders for the far edges. Each lit pixel
// yields one pixel_scale-square rectangle on the master side; tlast marks the last one of
// the character. A character is accepted, scanned one candidate pixel at a time up to its
// last lit pixel (at most 35), then the cursor advances; a blank glyph skips the scan. The
// slave side is not ready while a character is in progress. All coordinates saturate at
// 2^COORD_BITS-1 and leave on 16-bit fields. Configuration writes are always accepted and
// should be issued while idle.
module bitmap_font_text_rasterizer #(
    parameter int COORD_BITS = bfr_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side: character requests
    input  wire logic                             i_s_tvalid,
    output      logic                             o_s_tready,
    input  wire logic [bfr_pkg::CHAR_W-1:0]       i_s_tdata,   // [7:0] char_code
    input  wire logic                             i_s_tuser,   // [0] new_text
    // master side: rectangles
    output      logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [15:0] rect_left, [31:16] rect_top, [47:32] rect_right,
    // [63:48] rect_bottom, [95:64] pixel_color
    output      logic [4*bfr_pkg::RECT_W+bfr_pkg::COLOR_W-1:0] o_m_tdata,
    output      logic                             o_m_tlast,   // last_pixel
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [bfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bfr_pkg::COLOR_W-1:0]      i_cfg_data
);
    import bfr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int WW = (CW > START_W) ? CW : START_W;
    localparam logic [CW-1:0] CMAX = '1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_ADV  = 2'd2;

    // Clamp a start register into the cursor range.
    function automatic logic [CW-1:0] sat_start(input logic [START_W-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        if (w > WW'(CMAX)) begin
            return CMAX;
        end
        return CW'(w);
    endfunction

    // Sums below carry at most one bit past the cursor width.
    function automatic logic [CW-1:0] sat1(input logic [CW:0] v);
        return v[CW] ? CMAX : v[CW-1:0];
    endfunction

    // configuration registers
    logic [START_W-1:0] r_start_x, r_start_y;
    logic [SCALE_W-1:0] r_scale;
    logic [COLOR_W-1:0] r_color;

    // sequencer and cursor
    logic [1:0]            r_state;
    logic [CW-1:0]         r_cur_col, r_cur_row;
    t_glyph                r_bits;      // remaining candidates, current one on top
    logic [2:0]            r_col;       // column of the current candidate
    logic [CW:0]           r_x, r_y;    // unsaturated left / top of current candidate

    // output stage
    logic                  r_out_valid;
    logic                  r_out_last;
    logic [RECT_W-1:0]     r_out_left, r_out_top, r_out_right, r_out_bottom;
    logic [COLOR_W-1:0]    r_out_color;

    logic                  w_accept;
    logic                  w_newline;
    logic [CW-1:0]         w_base_col, w_base_row, w_start_col;
    t_glyph                w_glyph;
    logic [CW:0]           w_x1, w_y1;
    logic                  w_cur_bit, w_rest_empty, w_out_free, w_step, w_load;
    logic [CW:0]           w_row_nl, w_col_adv;
    logic [8:0]            w_nine_s, w_six_s;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign w_start_col = sat_start(r_start_x);
    assign w_base_col  = i_s_tuser ? w_start_col : r_cur_col;
    assign w_base_row  = i_s_tuser ? sat_start(r_start_y) : r_cur_row;
    assign w_newline   = (i_s_tdata == NEWLINE_CODE);
    assign w_glyph     = glyph_bits(i_s_tdata);

    // 9 x scale down for a newline, 6 x scale right after a character
    assign w_nine_s  = {1'b0, r_scale, 3'b000} + {4'b0000, r_scale};
    assign w_six_s   = {2'b00, r_scale, 2'b00} + {3'b000, r_scale, 1'b0};
    assign w_row_nl  = {1'b0, w_base_row} + (CW+1)'(w_nine_s);
    assign w_col_adv = {1'b0, r_cur_col} + (CW+1)'(w_six_s);

    // shared add unit: far edges of the current candidate square
    assign w_x1 = r_x + (CW+1)'(r_scale);
    assign w_y1 = r_y + (CW+1)'(r_scale);

    assign w_cur_bit    = r_bits[GLYPH_BITS-1];
    assign w_rest_empty = (r_bits[GLYPH_BITS-2:0] == '0);
    assign w_out_free   = !r_out_valid || i_m_tready;
    // unlit candidates pass freely; a lit one waits for room in the output stage
    assign w_step       = (r_state == ST_SCAN) && (!w_cur_bit || w_out_free);
    assign w_load       = w_step && w_cur_bit;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= START_RST;
            r_start_y <= START_RST;
            r_scale   <= SCALE_RST;
            r_color   <= COLOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_X: r_start_x <= i_cfg_data[START_W-1:0];
                REG_START_Y: r_start_y <= i_cfg_data[START_W-1:0];
                REG_SCALE:   r_scale   <= i_cfg_data[SCALE_W-1:0];
                REG_COLOR:   r_color   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, cursor and scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cur_col <= sat_start(START_RST);
            r_cur_row <= sat_start(START_RST);
            r_bits    <= '0;
            r_col     <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_newline) begin
                            // return carriage, drop a line; nothing to draw
                            r_cur_col <= w_start_col;
                            r_cur_row <= sat1(w_row_nl);
                        end else begin
                            r_cur_col <= w_base_col;
                            r_cur_row <= w_base_row;
                            r_bits    <= w_glyph;
                            r_col     <= '0;
                            r_state   <= (w_glyph == '0) ? ST_ADV : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_step) begin
                        r_bits <= r_bits << 1;
                        if (r_col == 3'(GLYPH_COLS - 1)) begin
                            r_col <= '0;
                        end else begin
                            r_col <= r_col + 3'd1;
                        end
                        if (w_rest_empty) begin
                            r_state <= ST_ADV;
                        end
                    end
                end
                ST_ADV: begin
                    r_cur_col <= sat1(w_col_adv);
                    r_state   <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // running square origin: step right by scale, wrap to the next row at the last column
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= {1'b0, w_base_col};
            r_y <= {1'b0, w_base_row};
        end else if (w_step) begin
            if (r_col == 3'(GLYPH_COLS - 1)) begin
                r_x <= {1'b0, r_cur_col};
                r_y <= w_y1;
            end else begin
                r_x <= w_x1;
            end
        end
    end

    // output stage: hold until taken, refill on a lit candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_left   <= RECT_W'(sat1(r_x));
            r_out_top    <= RECT_W'(sat1(r_y));
            r_out_right  <= RECT_W'(sat1(w_x1));
            r_out_bottom <= RECT_W'(sat1(w_y1));
            r_out_color  <= r_color;
            r_out_last   <= w_rest_empty;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_color, r_out_bottom, r_out_right, r_out_top, r_out_left};
    assign o_m_tlast  = r_out_last;

    // a scan never runs past the last lit pixel
    a_scan_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_bits != '0))
        else $error("scan active with no lit pixels left");

    // each row starts back at the cursor column
    a_row_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_col == '0) |-> (r_x == {1'b0, r_cur_col}))
        else $error("row scan does not start at cursor column");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_col < 3'(GLYPH_COLS)))
        else $error("column counter out of range");

    // the rectangle that ends a scan carries the last-pixel mark
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_rest_empty) |=> (r_out_valid && r_out_last && r_state == ST_ADV))
        else $error("final rectangle not marked last");

    // a newline draws nothing
    a_newline_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_newline) |=> (r_state == ST_IDLE))
        else $error("newline started a scan");

endmodule

`default_nettype wire
